### hw/rtl/bimom_pkg.sv
`timescale 1ns / 1ps

package bimom_pkg;

    localparam int PIX_W   = 8;
    localparam int COUNT_W = 25;
    localparam int SUM1_W  = 36;
    localparam int SUM2_W  = 48;

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SUM1_W-1:0]  sum1_t;
    typedef logic [SUM2_W-1:0]  sum2_t;

endpackage

### hw/rtl/bimom_if.sv
`timescale 1ns / 1ps

interface bimom_pixel_if;
    import bimom_pkg::*;

    logic valid;
    logic ready;
    pix_t pixels;
    logic end_of_row;
    logic end_of_image;

    modport source (output valid, output pixels, output end_of_row, output end_of_image,
                    input ready);
    modport sink (input valid, input pixels, input end_of_row, input end_of_image,
                  output ready);
endinterface

interface bimom_moment_if;
    import bimom_pkg::*;

    logic   valid;
    logic   ready;
    count_t pixel_count;
    sum1_t  sum_x;
    sum1_t  sum_y;
    sum2_t  sum_xx;
    sum2_t  sum_yy;
    sum2_t  sum_xy;

    modport source (output valid, output pixel_count, output sum_x, output sum_y,
                    output sum_xx, output sum_yy, output sum_xy, input ready);
    modport sink (input valid, input pixel_count, input sum_x, input sum_y,
                  input sum_xx, input sum_yy, input sum_xy, output ready);
endinterface

interface bimom_cfg_if;
    logic valid;
    logic ready;
    logic msb_first;

    modport source (output valid, output msb_first, input ready);
    modport sink (input valid, input msb_first, output ready);
endinterface

### hw/rtl/binary_image_second_order_moments.sv
// Raw moments up to second order of a binary image streamed as bytes of eight pixels.
// One byte is taken per cycle unless stalled, with no gaps across row and image ends.
// Work flows through six register stages (input, per-byte bit sums, byte weighting,
// row accumulation, row-by-y products, image totals), so the moments of an image
// appear on the result channel once its end-of-image byte has passed through them.
// While a result waits to be taken, bytes keep flowing; the input stalls only when
// the next image end reaches the row-product stage before the waiting result is gone.
// Pixels at or beyond column MAX_WIDTH and rows at or beyond MAX_HEIGHT are ignored.
// msb_first sets the leftmost pixel's bit; write it only while idle (unenforced).
`timescale 1ns / 1ps

module binary_image_second_order_moments #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    bimom_pixel_if.sink           pixel_ch,
    bimom_moment_if.source        moment_ch,
    bimom_cfg_if.sink             cfg
);
    import bimom_pkg::*;

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int CEIL = (MAX_WIDTH + 7) / 8;
    localparam int BCW  = $clog2(CEIL + 1);
    localparam int BW   = BCW + 3;
    localparam int BQW  = 2 * BW;
    localparam int RIW  = $clog2(MAX_HEIGHT + 1);
    localparam int YYW  = 2 * RIW;
    localparam int RCW  = $clog2(MAX_WIDTH + 1);
    localparam int RXW  = 2 * XW;
    localparam int RXXW = 3 * XW;
    localparam int DXW  = XW + 3;
    localparam int DXXW = 2 * XW + 3;

    localparam logic [BW:0]     WIDTH_LIM   = (BW + 1)'(MAX_WIDTH);
    localparam logic [BCW-1:0]  BC_LIM      = BCW'(CEIL);
    localparam logic [BQW-1:0]  BASE_SQ_LIM = BQW'(64'(CEIL * 8) * 64'(CEIL * 8));
    localparam logic [RIW-1:0]  HEIGHT_LIM  = RIW'(MAX_HEIGHT);

    logic advance;

    // configuration
    logic msb_first_reg;

    // input register
    logic       r1_valid_reg;
    pix_t       r1_pixels_reg;
    logic       r1_eor_reg;
    logic       r1_eoi_reg;

    // position state
    logic [BCW-1:0] bc_reg, bc_next;
    logic [BQW-1:0] base_sq_reg, base_sq_next;
    logic [RIW-1:0] row_index_reg, row_index_next;
    logic [YYW-1:0] yy_reg, yy_next;

    // stage 2
    logic            s2_valid_reg;
    logic            s2_eor_reg;
    logic            s2_eoi_reg;
    logic [3:0]      s2_cnt_reg;
    logic [4:0]      s2_sp_reg;
    logic [7:0]      s2_spp_reg;
    logic [XW-1:0]   s2_base_reg;
    logic [2*XW-1:0] s2_base_sq_reg;
    logic [RIW-1:0]  s2_y_reg;
    logic [YYW-1:0]  s2_yy_reg;

    // stage 3
    logic            s3_valid_reg;
    logic            s3_eor_reg;
    logic            s3_eoi_reg;
    logic [3:0]      s3_dc_reg;
    logic [DXW-1:0]  s3_dx_reg;
    logic [DXXW-1:0] s3_dxx_reg;
    logic [RIW-1:0]  s3_y_reg;
    logic [YYW-1:0]  s3_yy_reg;

    // row sums
    logic [RCW-1:0]  row_count_reg, row_count_next;
    logic [RXW-1:0]  row_xsum_reg, row_xsum_next;
    logic [RXXW-1:0] row_xxsum_reg, row_xxsum_next;

    // stage 4: finished row
    logic            s4_valid_reg;
    logic            s4_eor_reg;
    logic            s4_eoi_reg;
    logic [RCW-1:0]  s4_count_reg;
    logic [RXW-1:0]  s4_x_reg;
    logic [RXXW-1:0] s4_xx_reg;
    logic [RIW-1:0]  s4_y_reg;
    logic [YYW-1:0]  s4_yy_reg;

    // stage 5: row products
    logic            s5_valid_reg;
    logic            s5_eor_reg;
    logic            s5_eoi_reg;
    logic [RCW-1:0]  s5_count_reg;
    logic [RXW-1:0]  s5_x_reg;
    logic [RXXW-1:0] s5_xx_reg;
    sum1_t           s5_py_reg;
    sum2_t           s5_pyy_reg;
    sum2_t           s5_pxy_reg;

    // image totals
    count_t total_count_reg, total_count_next;
    sum1_t  total_x_reg, total_x_next;
    sum1_t  total_y_reg, total_y_next;
    sum2_t  total_xx_reg, total_xx_next;
    sum2_t  total_yy_reg, total_yy_next;
    sum2_t  total_xy_reg, total_xy_next;

    // result register
    logic   out_valid_reg;
    count_t out_count_reg;
    sum1_t  out_x_reg;
    sum1_t  out_y_reg;
    sum2_t  out_xx_reg;
    sum2_t  out_yy_reg;
    sum2_t  out_xy_reg;

    assign advance = !(s5_valid_reg && s5_eoi_reg && out_valid_reg && !moment_ch.ready);

    assign pixel_ch.ready = advance;
    assign cfg.ready      = 1'b1;

    assign moment_ch.valid       = out_valid_reg;
    assign moment_ch.pixel_count = out_count_reg;
    assign moment_ch.sum_x       = out_x_reg;
    assign moment_ch.sum_y       = out_y_reg;
    assign moment_ch.sum_xx      = out_xx_reg;
    assign moment_ch.sum_yy      = out_yy_reg;
    assign moment_ch.sum_xy      = out_xy_reg;

    // stage 1: masked bit sums of one byte
    logic [BW-1:0] base;
    logic          in_rows;
    logic [3:0]    cnt_c;
    logic [4:0]    sp_c;
    logic [7:0]    spp_c;
    logic          wrap_col;

    always_comb
    begin
        logic bit_on;
        logic x_ok;
        base    = {bc_reg, 3'b000};
        in_rows = row_index_reg < HEIGHT_LIM;
        cnt_c   = '0;
        sp_c    = '0;
        spp_c   = '0;
        for (int p = 0; p < 8; p++)
        begin
            bit_on = msb_first_reg ? r1_pixels_reg[7 - p] : r1_pixels_reg[p];
            x_ok   = ((BW + 1)'(base) + (BW + 1)'(p)) < WIDTH_LIM;
            if (bit_on && x_ok && in_rows)
            begin
                cnt_c = cnt_c + 4'd1;
                sp_c  = sp_c + 5'(p);
                spp_c = spp_c + 8'(p * p);
            end
        end
        wrap_col = !(((BW + 1)'(base) + (BW + 1)'(8)) < WIDTH_LIM);
    end

    always_comb
    begin
        bc_next        = bc_reg;
        base_sq_next   = base_sq_reg;
        row_index_next = row_index_reg;
        yy_next        = yy_reg;
        if (r1_eor_reg)
        begin
            bc_next      = '0;
            base_sq_next = '0;
        end
        else if (wrap_col)
        begin
            bc_next      = BC_LIM;
            base_sq_next = BASE_SQ_LIM;
        end
        else
        begin
            bc_next      = bc_reg + BCW'(1);
            base_sq_next = base_sq_reg + BQW'({base, 4'b0000}) + BQW'(64);
        end
        if (r1_eoi_reg)
        begin
            row_index_next = '0;
            yy_next        = '0;
        end
        else if (r1_eor_reg && in_rows)
        begin
            row_index_next = row_index_reg + RIW'(1);
            yy_next        = yy_reg + YYW'({row_index_reg, 1'b1});
        end
    end

    // stage 2: weight bit sums by byte position
    logic [DXW-1:0]  dx_c;
    logic [DXXW-1:0] dxx_c;

    always_comb
    begin
        dx_c  = DXW'(DXW'(s2_cnt_reg) * DXW'(s2_base_reg)) + DXW'(s2_sp_reg);
        dxx_c = DXXW'(DXXW'(s2_cnt_reg) * DXXW'(s2_base_sq_reg))
              + DXXW'({DXXW'(DXXW'(s2_base_reg) * DXXW'(s2_sp_reg)), 1'b0})
              + DXXW'(s2_spp_reg);
    end

    // stage 3: row accumulation
    always_comb
    begin
        row_count_next = row_count_reg + RCW'(s3_dc_reg);
        row_xsum_next  = row_xsum_reg + RXW'(s3_dx_reg);
        row_xxsum_next = row_xxsum_reg + RXXW'(s3_dxx_reg);
    end

    // stage 5: image totals
    always_comb
    begin
        total_count_next = total_count_reg;
        total_x_next     = total_x_reg;
        total_y_next     = total_y_reg;
        total_xx_next    = total_xx_reg;
        total_yy_next    = total_yy_reg;
        total_xy_next    = total_xy_reg;
        if (s5_eor_reg)
        begin
            total_count_next = total_count_reg + COUNT_W'(s5_count_reg);
            total_x_next     = total_x_reg + SUM1_W'(s5_x_reg);
            total_y_next     = total_y_reg + s5_py_reg;
            total_xx_next    = total_xx_reg + SUM2_W'(s5_xx_reg);
            total_yy_next    = total_yy_reg + s5_pyy_reg;
            total_xy_next    = total_xy_reg + s5_pxy_reg;
        end
    end

    // control and accumulator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msb_first_reg   <= 1'b0;
            r1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            s4_valid_reg    <= 1'b0;
            s5_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            bc_reg          <= '0;
            base_sq_reg     <= '0;
            row_index_reg   <= '0;
            yy_reg          <= '0;
            row_count_reg   <= '0;
            row_xsum_reg    <= '0;
            row_xxsum_reg   <= '0;
            total_count_reg <= '0;
            total_x_reg     <= '0;
            total_y_reg     <= '0;
            total_xx_reg    <= '0;
            total_yy_reg    <= '0;
            total_xy_reg    <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                msb_first_reg <= cfg.msb_first;
            end
            if (advance && s5_valid_reg && s5_eoi_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (moment_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                r1_valid_reg <= pixel_ch.valid;
                s2_valid_reg <= r1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
                s5_valid_reg <= s4_valid_reg;
                if (r1_valid_reg)
                begin
                    bc_reg        <= bc_next;
                    base_sq_reg   <= base_sq_next;
                    row_index_reg <= row_index_next;
                    yy_reg        <= yy_next;
                end
                if (s3_valid_reg)
                begin
                    if (s3_eor_reg)
                    begin
                        row_count_reg <= '0;
                        row_xsum_reg  <= '0;
                        row_xxsum_reg <= '0;
                    end
                    else
                    begin
                        row_count_reg <= row_count_next;
                        row_xsum_reg  <= row_xsum_next;
                        row_xxsum_reg <= row_xxsum_next;
                    end
                end
                if (s5_valid_reg)
                begin
                    if (s5_eoi_reg)
                    begin
                        total_count_reg <= '0;
                        total_x_reg     <= '0;
                        total_y_reg     <= '0;
                        total_xx_reg    <= '0;
                        total_yy_reg    <= '0;
                        total_xy_reg    <= '0;
                    end
                    else
                    begin
                        total_count_reg <= total_count_next;
                        total_x_reg     <= total_x_next;
                        total_y_reg     <= total_y_next;
                        total_xx_reg    <= total_xx_next;
                        total_yy_reg    <= total_yy_next;
                        total_xy_reg    <= total_xy_next;
                    end
                end
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            r1_pixels_reg <= pixel_ch.pixels;
            r1_eor_reg    <= pixel_ch.end_of_row | pixel_ch.end_of_image;
            r1_eoi_reg    <= pixel_ch.end_of_image;

            s2_eor_reg     <= r1_eor_reg;
            s2_eoi_reg     <= r1_eoi_reg;
            s2_cnt_reg     <= cnt_c;
            s2_sp_reg      <= sp_c;
            s2_spp_reg     <= spp_c;
            s2_base_reg    <= XW'(base);
            s2_base_sq_reg <= (2 * XW)'(base_sq_reg);
            s2_y_reg       <= row_index_reg;
            s2_yy_reg      <= yy_reg;

            s3_eor_reg <= s2_eor_reg;
            s3_eoi_reg <= s2_eoi_reg;
            s3_dc_reg  <= s2_cnt_reg;
            s3_dx_reg  <= dx_c;
            s3_dxx_reg <= dxx_c;
            s3_y_reg   <= s2_y_reg;
            s3_yy_reg  <= s2_yy_reg;

            s4_eor_reg   <= s3_eor_reg;
            s4_eoi_reg   <= s3_eoi_reg;
            s4_count_reg <= row_count_next;
            s4_x_reg     <= row_xsum_next;
            s4_xx_reg    <= row_xxsum_next;
            s4_y_reg     <= s3_y_reg;
            s4_yy_reg    <= s3_yy_reg;

            s5_eor_reg   <= s4_eor_reg;
            s5_eoi_reg   <= s4_eoi_reg;
            s5_count_reg <= s4_count_reg;
            s5_x_reg     <= s4_x_reg;
            s5_xx_reg    <= s4_xx_reg;
            s5_py_reg    <= SUM1_W'(SUM1_W'(s4_count_reg) * SUM1_W'(s4_y_reg));
            s5_pyy_reg   <= SUM2_W'(SUM2_W'(s4_count_reg) * SUM2_W'(s4_yy_reg));
            s5_pxy_reg   <= SUM2_W'(SUM2_W'(s4_x_reg) * SUM2_W'(s4_y_reg));

            if (s5_valid_reg && s5_eoi_reg)
            begin
                out_count_reg <= total_count_next;
                out_x_reg     <= total_x_next;
                out_y_reg     <= total_y_next;
                out_xx_reg    <= total_xx_next;
                out_yy_reg    <= total_yy_next;
                out_xy_reg    <= total_xy_next;
            end
        end
    end

    // incremental squares track their positions
    a_base_sq: assert property (@(posedge clk) disable iff (!rst_n)
        base_sq_reg == BQW'(BQW'(base) * BQW'(base)))
        else $error("base square out of step with byte column");

    a_row_sq: assert property (@(posedge clk) disable iff (!rst_n)
        yy_reg == YYW'(YYW'(row_index_reg) * YYW'(row_index_reg)))
        else $error("row square out of step with row index");

    a_limits: assert property (@(posedge clk) disable iff (!rst_n)
        bc_reg <= BC_LIM && row_index_reg <= HEIGHT_LIM)
        else $error("position beyond its limit");

    a_image_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && r1_valid_reg && r1_eoi_reg) |=> (bc_reg == '0 && row_index_reg == '0))
        else $error("position not cleared after image end");

endmodule

### tb/bimom_moment_watch.sv
`timescale 1ns / 1ps

module bimom_moment_watch #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic    clk,
    input  logic    rst_n,
    bimom_pixel_if  pix_ch,
    bimom_moment_if mom_ch,
    bimom_cfg_if    cfg_ch,
    output int      fail_count,
    output int      waiting_count
);
    import bimom_pkg::*;

    typedef struct {
        count_t n;
        sum1_t  sx;
        sum1_t  sy;
        sum2_t  sxx;
        sum2_t  syy;
        sum2_t  sxy;
    } moments_t;

    moments_t    moments_q[$];
    moments_t    got;
    moments_t    want;
    logic        msb_first;
    int unsigned byte_col;
    int unsigned row_idx;
    logic [12:0] row_n;
    logic [23:0] row_sx;
    logic [35:0] row_sxx;
    count_t      tot_n;
    sum1_t       tot_x;
    sum1_t       tot_y;
    sum2_t       tot_xx;
    sum2_t       tot_yy;
    sum2_t       tot_xy;
    int          fails;

    function automatic void clear_image();
        byte_col = 0;
        row_idx  = 0;
        row_n    = '0;
        row_sx   = '0;
        row_sxx  = '0;
        tot_n    = '0;
        tot_x    = '0;
        tot_y    = '0;
        tot_xx   = '0;
        tot_yy   = '0;
        tot_xy   = '0;
    endfunction

    function automatic void take_byte(pix_t b, logic eor_in, logic eoi);
        logic          eor;
        int unsigned   base_x;
        int unsigned   x;
        logic [63:0]   y;
        moments_t      m;
        eor = eor_in | eoi;
        base_x = byte_col * 8;
        if (row_idx < MAX_HEIGHT)
        begin
            for (int p = 0; p < 8; p++)
            begin
                x = base_x + p;
                if (b[msb_first ? 7 - p : p] && x < MAX_WIDTH)
                begin
                    row_n   = row_n + 13'd1;
                    row_sx  = row_sx + 24'(x);
                    row_sxx = row_sxx + 36'(x * x);
                end
            end
        end
        if (base_x + 8 < MAX_WIDTH)
            byte_col = byte_col + 1;
        else
            byte_col = (MAX_WIDTH + 7) / 8;
        if (eor)
        begin
            y = 64'(row_idx);
            tot_n  = tot_n + COUNT_W'(row_n);
            tot_x  = tot_x + SUM1_W'(row_sx);
            tot_y  = tot_y + SUM1_W'(64'(row_n) * y);
            tot_xx = tot_xx + SUM2_W'(row_sxx);
            tot_yy = tot_yy + SUM2_W'(64'(row_n) * y * y);
            tot_xy = tot_xy + SUM2_W'(64'(row_sx) * y);
            byte_col = 0;
            row_n    = '0;
            row_sx   = '0;
            row_sxx  = '0;
            if (row_idx < MAX_HEIGHT)
                row_idx = row_idx + 1;
        end
        if (eoi)
        begin
            m.n   = tot_n;
            m.sx  = tot_x;
            m.sy  = tot_y;
            m.sxx = tot_xx;
            m.syy = tot_yy;
            m.sxy = tot_xy;
            moments_q.push_back(m);
            clear_image();
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            fails++;
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        end
    endfunction

    initial
    begin
        fails = 0;
        msb_first = 1'b0;
        clear_image();
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msb_first = 1'b0;
            clear_image();
        end
        else
        begin
            if (mom_ch.valid && mom_ch.ready)
            begin
                if (moments_q.size() == 0)
                begin
                    fails++;
                    $error("moment result transfer with nothing expected");
                end
                else
                begin
                    want = moments_q.pop_front();
                    got.n   = mom_ch.pixel_count;
                    got.sx  = mom_ch.sum_x;
                    got.sy  = mom_ch.sum_y;
                    got.sxx = mom_ch.sum_xx;
                    got.syy = mom_ch.sum_yy;
                    got.sxy = mom_ch.sum_xy;
                    check_field("pixel_count", want.n, got.n);
                    check_field("sum_x", want.sx, got.sx);
                    check_field("sum_y", want.sy, got.sy);
                    check_field("sum_xx", want.sxx, got.sxx);
                    check_field("sum_yy", want.syy, got.syy);
                    check_field("sum_xy", want.sxy, got.sxy);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                msb_first = cfg_ch.msb_first;
            if (pix_ch.valid && pix_ch.ready)
                take_byte(pix_ch.pixels, pix_ch.end_of_row, pix_ch.end_of_image);
        end
        fail_count    <= fails;
        waiting_count <= moments_q.size();
    end

endmodule

### tb/binary_image_second_order_moments_test.sv
`timescale 1ns / 1ps

module binary_image_second_order_moments_test;
    import bimom_pkg::*;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   gap_pct;
    int   stall_left;
    int   items_sent;
    int   phase;
    int   fail_count;
    int   waiting_count;

    bimom_pixel_if  pix_ch ();
    bimom_moment_if mom_ch ();
    bimom_cfg_if    cfg_ch ();

    binary_image_second_order_moments #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_ch  (pix_ch),
        .moment_ch (mom_ch),
        .cfg       (cfg_ch)
    );

    bimom_moment_watch #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_moment_watch (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix_ch        (pix_ch),
        .mom_ch        (mom_ch),
        .cfg_ch        (cfg_ch),
        .fail_count    (fail_count),
        .waiting_count (waiting_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("binary_image_second_order_moments_test: done, errors");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        stall_left = 0;
        mom_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
            begin
                stall_left--;
                mom_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(5) == 0)
            begin
                stall_left = $urandom_range(1, 4) - 1;
                mom_ch.ready <= 1'b0;
            end
            else
                mom_ch.ready <= 1'b1;
        end
    end

    task automatic send_byte(pix_t b, logic eor, logic eoi);
        int gap;
        if (!quiet && $urandom_range(99) < gap_pct)
        begin
            gap = $urandom_range(1, 4);
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid        <= 1'b1;
        pix_ch.pixels       <= b;
        pix_ch.end_of_row   <= eor;
        pix_ch.end_of_image <= eoi;
        do @(posedge clk); while (!pix_ch.ready);
        items_sent++;
    endtask

    function automatic pix_t pick_pixels();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return pix_t'(1) << $urandom_range(7);
            default: return pix_t'($urandom);
        endcase
    endfunction

    task automatic send_image(int rows, int max_len);
        int  len;
        bit  last;
        for (int r = 0; r < rows; r++)
        begin
            len = $urandom_range(1, max_len);
            for (int i = 0; i < len; i++)
            begin
                last = (r == rows - 1) && (i == len - 1);
                // image end may come without its row end
                if (last)
                    send_byte(pick_pixels(), 1'($urandom_range(1)), 1'b1);
                else
                    send_byte(pick_pixels(), i == len - 1, 1'b0);
            end
        end
    endtask

    task automatic write_cfg(logic v);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.msb_first <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (waiting_count != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        quiet         = 1'b0;
        gap_pct       = 0;
        items_sent    = 0;
        rst_n                <= 1'b0;
        pix_ch.valid         <= 1'b0;
        pix_ch.pixels        <= '0;
        pix_ch.end_of_row    <= 1'b0;
        pix_ch.end_of_image  <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.msb_first     <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset bit order: empty image, image end without row end
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(8'h80, 1'b1, 1'b1);
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte(8'h55, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'h0F, 1'b0, 1'b1);
        drain();
        write_cfg(1'b1);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h80, 1'b1, 1'b0);
        send_byte(8'hC3, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h00, 1'b1, 1'b1);
        drain();

        phase = 0;
        while (items_sent < 1050)
        begin
            quiet = items_sent > 950;
            write_cfg(1'(phase % 2));
            case ($urandom_range(2))
                0: gap_pct = 0;
                1: gap_pct = 20;
                default: gap_pct = 50;
            endcase
            // row wider than the column limit
            if (phase == 2)
            begin
                for (int i = 0; i < 520; i++)
                    send_byte(pick_pixels(), i == 519, 1'b0);
                send_image(2, 4);
            end
            repeat ($urandom_range(2, 6))
                send_image($urandom_range(1, 6), $urandom_range(1, 8));
            drain();
            phase++;
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("binary_image_second_order_moments_test: done, clean");
        else
            $display("binary_image_second_order_moments_test: done, errors");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/bimom_pkg.sv
hw/rtl/bimom_if.sv
hw/rtl/binary_image_second_order_moments.sv
tb/bimom_moment_watch.sv
tb/binary_image_second_order_moments_test.sv
